[rtl/cfr_pkg.sv]
// package for the checksummed frame receiver
// holds sizes, status codes, register indexes and the controller/datapath types
// no dependencies
package cfr_pkg;

    localparam int BUFFER_BYTES = 32;
    localparam int FILL_W       = $clog2(BUFFER_BYTES);
    localparam int MAX_PAYLOAD  = 30;
    localparam int BYTE_W       = 8;
    localparam int IDX_W        = 5;
    localparam int LEN_W        = 5;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CSUM = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LEN  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_OVF  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_LEN    = 2'd2;

    localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd165;
    localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'd90;
    localparam logic [LEN_W-1:0]  EXP_LEN_RST    = 5'd4;

    typedef enum logic [1:0] {
        S_HUNT,
        S_RECV,
        S_READ,
        S_EMIT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic                store;
        logic                close;
        logic                load_err;
        logic [STATUS_W-1:0] err_code;
        logic                rd_en;
        logic                rd_next;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic is_start;
        logic is_end;
        logic full_next;
        logic empty;
        logic csum_ok;
        logic len_ok;
        logic out_last;
    } t_dp_sts;

endpackage

[rtl/checksummed_frame_receiver.sv]
// top level of the checksummed frame receiver
// joins cfr_ctrl and cfr_dp; depends on cfr_pkg
//
// Usage:
// - input stream: one received link byte per transaction on i_s_tdata.
//   While idle the block waits for the start byte; then it buffers bytes
//   until the end byte. The last buffered byte is an additive checksum.
// - output stream: per frame either every payload byte in order
//   (tuser status 0, tlast on the final byte) or one error transaction
//   (checksum, length or overflow) with zero data and tlast set.
// - config channel: i_cfg_index selects start byte, end byte or expected
//   payload length; o_cfg_ready is always high.
// Timing:
// - a byte is taken whenever a frame is hunted or received.
// - an error result shows in the cycle after the byte that causes it.
// - a good frame: after the end byte, each payload byte goes through a buffer
//   read, then the output register; the next read starts once it is taken,
//   and input is held off until the last one is taken.
// - reset returns to hunting with the register reset values; no clearing
//   pass is run. A stalled output holds its transaction and the input stays
//   blocked until it is taken.
module checksummed_frame_receiver
    import cfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    // input stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [7:0]           i_s_tdata,   // [7:0] rx_byte
    // output stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [15:0]          o_m_tdata,   // [7:0] payload_byte, [12:8] byte_index
    output logic [1:0]           o_m_tuser,   // [1:0] status
    output logic                 o_m_tlast
);

    t_dp_cmd             cmd;
    t_dp_sts             sts;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   payload_byte;
    logic [IDX_W-1:0]    byte_index;
    logic                last;

    assign o_cfg_ready = 1'b1;

    cfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cfr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_rx_byte      (i_s_tdata),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_status       (status),
        .o_payload_byte (payload_byte),
        .o_byte_index   (byte_index),
        .o_last         (last)
    );

    assign o_m_tdata = {3'b000, byte_index, payload_byte};
    assign o_m_tuser = status;
    assign o_m_tlast = last;

endmodule

[rtl/cfr_dp.sv]
// datapath of the checksummed frame receiver: config registers, frame buffer,
// running checksum, read pointer and result registers
// depends on cfr_pkg
module cfr_dp
    import cfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output logic [STATUS_W-1:0]  o_status,
    output logic [BYTE_W-1:0]    o_payload_byte,
    output logic [IDX_W-1:0]     o_byte_index,
    output logic                 o_last
);

    logic [BYTE_W-1:0]   r_start_byte;
    logic [BYTE_W-1:0]   r_end_byte;
    logic [LEN_W-1:0]    r_exp_len;

    logic [BYTE_W-1:0]   r_mem [BUFFER_BYTES];
    logic [BYTE_W-1:0]   r_rd_data;

    logic [FILL_W-1:0]   r_fill;
    logic [BYTE_W-1:0]   r_sum_all;
    logic [BYTE_W-1:0]   r_sum_prev;
    logic [BYTE_W-1:0]   r_last_byte;

    logic [FILL_W-1:0]   r_rd_idx;
    logic [FILL_W-1:0]   r_plen;
    logic                r_err;
    logic [STATUS_W-1:0] r_err_code;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RST;
            r_end_byte   <= END_BYTE_RST;
            r_exp_len    <= EXP_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_START_BYTE: r_start_byte <= i_cfg_data;
                REG_END_BYTE:   r_end_byte   <= i_cfg_data;
                REG_EXP_LEN:    r_exp_len    <= i_cfg_data[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    // frame buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_fill] <= i_rx_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    // fill count, running sums and the emit pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_sum_all  <= '0;
            r_sum_prev <= '0;
            r_err      <= 1'b0;
            r_rd_idx   <= '0;
        end else begin
            if (i_cmd.store) begin
                r_fill     <= r_fill + FILL_W'(1);
                r_sum_prev <= r_sum_all;
                r_sum_all  <= r_sum_all + i_rx_byte;
            end
            if (i_cmd.close || i_cmd.load_err) begin
                r_fill     <= '0;
                r_sum_all  <= '0;
                r_sum_prev <= '0;
                r_rd_idx   <= '0;
                r_err      <= i_cmd.load_err;
            end
            if (i_cmd.rd_next) begin
                r_rd_idx <= r_rd_idx + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_last_byte <= i_rx_byte;
        end
        if (i_cmd.close) begin
            r_plen <= r_fill - FILL_W'(1);
        end
        if (i_cmd.load_err) begin
            r_err_code <= i_cmd.err_code;
        end
    end

    always_comb begin
        o_sts.is_start  = (i_rx_byte == r_start_byte);
        o_sts.is_end    = (i_rx_byte == r_end_byte);
        o_sts.full_next = (r_fill == FILL_W'(BUFFER_BYTES - 1));
        o_sts.empty     = (r_fill == '0);
        // checksum byte is the last one stored, compared with the sum before it
        o_sts.csum_ok   = (r_last_byte == r_sum_prev);
        o_sts.len_ok    = (r_exp_len != '0) && (r_exp_len <= LEN_W'(MAX_PAYLOAD))
                          && (8'(r_fill) == 8'(r_exp_len) + 8'd1);
        o_sts.out_last  = r_err || (r_rd_idx == r_plen - FILL_W'(1));
    end

    assign o_status       = r_err ? r_err_code : STATUS_OK;
    assign o_payload_byte = r_err ? '0 : r_rd_data;
    assign o_byte_index   = r_err ? '0 : IDX_W'(r_rd_idx);
    assign o_last         = o_sts.out_last;

endmodule

[rtl/cfr_ctrl.sv]
// controller of the checksummed frame receiver: frame hunt, receive,
// buffer read-out and result handshake
// depends on cfr_pkg
module cfr_ctrl
    import cfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   in_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = (r_state == S_HUNT) || (r_state == S_RECV);
        o_m_tvalid = (r_state == S_EMIT);
        in_acc     = i_s_tvalid && o_s_tready;

        unique case (r_state)
            S_HUNT: begin
                if (in_acc && i_sts.is_start) begin
                    n_state = S_RECV;
                end
            end
            S_RECV: begin
                if (in_acc) begin
                    if (i_sts.is_end) begin
                        if (i_sts.empty) begin
                            o_cmd.load_err = 1'b1;
                            o_cmd.err_code = STATUS_LEN;
                            n_state        = S_EMIT;
                        end else if (!i_sts.csum_ok) begin
                            o_cmd.load_err = 1'b1;
                            o_cmd.err_code = STATUS_CSUM;
                            n_state        = S_EMIT;
                        end else if (!i_sts.len_ok) begin
                            o_cmd.load_err = 1'b1;
                            o_cmd.err_code = STATUS_LEN;
                            n_state        = S_EMIT;
                        end else begin
                            o_cmd.close = 1'b1;
                            n_state     = S_READ;
                        end
                    end else begin
                        o_cmd.store = 1'b1;
                        // this byte fills the buffer: drop the frame
                        if (i_sts.full_next) begin
                            o_cmd.load_err = 1'b1;
                            o_cmd.err_code = STATUS_OVF;
                            n_state        = S_EMIT;
                        end
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_m_tready) begin
                    if (i_sts.out_last) begin
                        n_state = S_HUNT;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                        n_state       = S_READ;
                    end
                end
            end
            default: n_state = S_HUNT;
        endcase
    end

endmodule

[tb/sv/checksummed_frame_receiver_test.sv]
// self-checking bench for checksummed_frame_receiver: framed link bytes in, payload or error out
// depends on cfr_pkg and the rtl top; a small class predicts and checks the output stream
`timescale 1ns / 1ps

import cfr_pkg::*;

typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   payload;
    logic [IDX_W-1:0]    index;
    logic                last;
} t_frame_result;

class frame_checker;
    logic [BYTE_W-1:0] start_val;
    logic [BYTE_W-1:0] end_val;
    logic [LEN_W-1:0]  exp_len;
    bit                receiving;
    int                fill;
    logic [BYTE_W-1:0] frame_buf [BUFFER_BYTES];
    t_frame_result     due_results [$];
    int                mismatches;

    function new();
        start_val  = START_BYTE_RST;
        end_val    = END_BYTE_RST;
        exp_len    = EXP_LEN_RST;
        receiving  = 1'b0;
        fill       = 0;
        mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
        case (idx)
            REG_START_BYTE: start_val = val;
            REG_END_BYTE:   end_val = val;
            REG_EXP_LEN:    exp_len = val[LEN_W-1:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return due_results.size();
    endfunction

    function void push_error(logic [STATUS_W-1:0] code);
        due_results.push_back('{status: code, payload: '0, index: '0, last: 1'b1});
    endfunction

    // one accepted link byte; appends whatever results it causes
    function void take_link_byte(logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] sum;
        int plen;
        if (!receiving) begin
            if (b == start_val)
                receiving = 1'b1;
        end else if (b == end_val) begin
            plen = fill - 1;
            receiving = 1'b0;
            fill = 0;
            sum = '0;
            if (plen < 0) begin
                push_error(STATUS_LEN);
            end else begin
                for (int i = 0; i < plen; i++)
                    sum = sum + frame_buf[i];
                if (frame_buf[plen] != sum)
                    push_error(STATUS_CSUM);
                else if (exp_len == 0 || exp_len > MAX_PAYLOAD || plen != int'(exp_len))
                    push_error(STATUS_LEN);
                else
                    for (int i = 0; i < plen; i++)
                        due_results.push_back('{status: STATUS_OK, payload: frame_buf[i],
                                                index: IDX_W'(i), last: (i == plen - 1)});
            end
        end else begin
            frame_buf[fill] = b;
            fill++;
            if (fill >= BUFFER_BYTES) begin
                receiving = 1'b0;
                fill = 0;
                push_error(STATUS_OVF);
            end
        end
    endfunction

    function void check_output(logic [STATUS_W-1:0] status, logic [BYTE_W-1:0] payload,
                               logic [IDX_W-1:0] index, logic last);
        t_frame_result want;
        if (due_results.size() == 0) begin
            $error("output transaction with nothing expected: status %0d data %0h",
                   status, payload);
            mismatches++;
            return;
        end
        want = due_results.pop_front();
        if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatches++;
        end
        if (payload !== want.payload) begin
            $error("payload_byte: expected %0h, got %0h", want.payload, payload);
            mismatches++;
        end
        if (index !== want.index) begin
            $error("byte_index: expected %0d, got %0d", want.index, index);
            mismatches++;
        end
        if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            mismatches++;
        end
    endfunction
endclass

module checksummed_frame_receiver_test;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASES       = 8;
    localparam int PHASE_BYTES  = 32;
    localparam int HOLD_CYCLES  = 300;

    localparam logic [7:0] PH_START [PHASES] =
        '{8'hA5, 8'h00, 8'hFF, 8'h3C, 8'h81, 8'h12, 8'h00, 8'hA5};
    localparam logic [7:0] PH_END [PHASES] =
        '{8'h5A, 8'hFF, 8'h00, 8'h3C, 8'h7E, 8'hED, 8'h00, 8'h5A};
    localparam logic [7:0] PH_LEN [PHASES] =
        '{8'd4, 8'd1, 8'd30, 8'd7, 8'd0, 8'hFF, 8'd0, 8'hE3};

    logic                 i_clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic [7:0]           s_tdata = '0;
    logic                 m_tready = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [15:0]          o_m_tdata;
    logic [1:0]           o_m_tuser;
    logic                 o_m_tlast;

    frame_checker sb;
    int bytes_sent = 0;
    int burst_left = 0;
    bit hold_req = 1'b0;

    checksummed_frame_receiver u_top (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("checksummed_frame_receiver_test failed");
        $finish;
    end

    // outputs are read at the edge, before any register in the block updates
    always @(posedge i_clk) begin
        if (rst_n && o_m_tvalid && m_tready)
            sb.check_output(o_m_tuser, o_m_tdata[7:0], o_m_tdata[12:8], o_m_tlast);
    end

    // output side: stall modes that change every so often, plus one long hold-off
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        int tick;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(3, 0);
                mode_left = $urandom_range(120, 20);
            end
            mode_left--;
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(1, 0) == 0);
                    2: m_tready <= (tick % 3 == 0);
                    default: m_tready <= ($urandom_range(9, 0) != 0);
                endcase
            end
        end
    end

    function automatic logic [7:0] non_end();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == sb.end_val)
            b = ~b;
        return b;
    endfunction

    // sender works in bursts; valid stays up between back-to-back bytes
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(8, 0);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(24, 1);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge i_clk); while (!o_s_tready);
        sb.take_link_byte(b);
        bytes_sent++;
        burst_left--;
    endtask

    task automatic send_frame(input int plen, input bit corrupt);
        logic [7:0] body [$];
        logic [7:0] sum;
        logic [7:0] b;
        sum = '0;
        for (int i = 0; i < plen; i++) begin
            b = non_end();
            body.push_back(b);
            sum = sum + b;
        end
        if (corrupt)
            sum = sum + 8'($urandom_range(255, 1));
        if (sum == sb.end_val)
            sum = sum ^ 8'h01;
        send_byte(sb.start_val);
        foreach (body[i])
            send_byte(body[i]);
        send_byte(sum);
        send_byte(sb.end_val);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic load_config(input logic [7:0] sval, input logic [7:0] eval,
                               input logic [7:0] lval);
        write_reg(REG_START_BYTE, sval);
        write_reg(REG_END_BYTE, eval);
        write_reg(REG_EXP_LEN, lval);
        write_reg(REG_UNUSED, 8'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // block is idle once every expected result is out and a few cycles have passed
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int budget);
        int stop_at;
        int pick;
        int want;
        int plen;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99, 0);
            if (pick < 65) begin
                want = int'(sb.exp_len);
                if (want >= 1 && want <= MAX_PAYLOAD && $urandom_range(9, 0) < 8)
                    plen = want;
                else if ($urandom_range(3, 0) == 0)
                    plen = $urandom_range(BUFFER_BYTES - 1, 0);
                else
                    plen = $urandom_range(8, 0);
                send_frame(plen, $urandom_range(6, 0) == 0);
            end else if (pick < 75) begin
                repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
            end else if (pick < 80) begin
                send_byte(sb.end_val);
            end else if (pick < 87) begin
                // empty frame
                send_byte(sb.start_val);
                send_byte(sb.end_val);
            end else if (pick < 93) begin
                // runaway frame that fills the buffer
                send_byte(sb.start_val);
                repeat (BUFFER_BYTES) send_byte(non_end());
            end else begin
                // frame cut short, left open for later bytes
                send_byte(sb.start_val);
                repeat ($urandom_range(5, 1)) send_byte(non_end());
            end
        end
        if (sb.receiving)
            send_byte(sb.end_val);
    endtask

    initial begin
        logic [7:0] seq [$];
        logic [7:0] sval;
        logic [7:0] eval;
        sb = new();
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: stray end byte, good frame with extremes and an inner
        // start byte, empty frame, bad checksum, short frame
        seq = {8'h5A,
               8'hA5, 8'h00, 8'hFF, 8'hA5, 8'h01, 8'hA5, 8'h5A,
               8'hA5, 8'h5A,
               8'hA5, 8'd10, 8'd20, 8'd30, 8'd40, 8'd99, 8'h5A,
               8'hA5, 8'd7, 8'd9, 8'd16, 8'h5A};
        foreach (seq[i])
            send_byte(seq[i]);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            sval = PH_START[ph];
            eval = PH_END[ph];
            if (ph == 6) begin
                sval = 8'($urandom);
                eval = 8'($urandom);
                if (eval == sval)
                    eval = ~sval;
                load_config(sval, eval, 8'($urandom_range(MAX_PAYLOAD, 1)));
            end else begin
                load_config(sval, eval, PH_LEN[ph]);
            end
            // long frames with the output held off: the input has to back up
            if (ph == 2)
                hold_req = 1'b1;
            run_phase(PHASE_BYTES);
        end

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("checksummed_frame_receiver_test passed");
        else
            $display("checksummed_frame_receiver_test failed");
        $finish;
    end

endmodule
